// ----- design/bfs_pkg.sv -----
// ============================================================================
// bfs_pkg
// Shared types, codes and constants of the searchable queue.
// ============================================================================
package bfs_pkg;

    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int CAP_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // APB register map: one 32-bit register per word
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = APB_ADDR_W - 2;

    localparam logic [REG_SEL_W-1:0] REG_CAPACITY = 1'b0;

    // Operation codes of the input channel
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ENQUEUED  = 3'd0,
        STATUS_OVERFLOW  = 3'd1,
        STATUS_DEQUEUED  = 3'd2,
        STATUS_UNDERFLOW = 3'd3,
        STATUS_FOUND     = 3'd4,
        STATUS_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_KEY,
        VAL_RAM
    } val_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     enq_write;
        logic     deq_read;
        logic     deq_post;
        logic     scan_start;
        logic     scan_step;
        logic     post;
        status_t  post_status;
        val_sel_t post_val;
    } bfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              scan_done;
        logic              hit;
        logic              out_free;
    } bfs_stat_t;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int cnt_width(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

// ----- design/bfs_ram.sv -----
// ============================================================================
// bfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bfs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/bfs_ctrl.sv -----
// ============================================================================
// bfs_ctrl
// Sequencer of the searchable queue: takes one transaction at a time and
// steps the datapath through enqueue, dequeue or search.
// ============================================================================
module bfs_ctrl
    import bfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bfs_stat_t stat,
    output bfs_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEQ_WAIT,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd         = '0;
        cmd.post_status = STATUS_ENQUEUED;
        cmd.post_val    = VAL_ZERO;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.func)
                    FUNC_ENQUEUE: begin
                        if (stat.out_free) begin
                            cmd.post = 1'b1;
                            if (stat.full) begin
                                cmd.post_status = STATUS_OVERFLOW;
                                cmd.post_val    = VAL_ZERO;
                            end else begin
                                cmd.enq_write   = 1'b1;
                                cmd.post_status = STATUS_ENQUEUED;
                                cmd.post_val    = VAL_KEY;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_DEQUEUE: begin
                        if (stat.empty) begin
                            if (stat.out_free) begin
                                cmd.post        = 1'b1;
                                cmd.post_status = STATUS_UNDERFLOW;
                                cmd.post_val    = VAL_ZERO;
                                state_next      = ST_IDLE;
                            end
                        end else begin
                            cmd.deq_read = 1'b1;
                            state_next   = ST_DEQ_WAIT;
                        end
                    end
                    default: begin
                        // search, and the unused code that decodes as search
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                endcase
            end
            ST_DEQ_WAIT: begin
                if (stat.out_free) begin
                    cmd.deq_post    = 1'b1;
                    cmd.post        = 1'b1;
                    cmd.post_status = STATUS_DEQUEUED;
                    cmd.post_val    = VAL_RAM;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done && stat.out_free) begin
                    cmd.post        = 1'b1;
                    cmd.post_status = stat.hit ? STATUS_FOUND : STATUS_NOT_FOUND;
                    cmd.post_val    = VAL_KEY;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ----- design/bfs_dp.sv -----
// ============================================================================
// bfs_dp
// Datapath of the searchable queue: pointers, count, entry RAM, search scan
// and the result register.
// ============================================================================
module bfs_dp
    import bfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [DATA_W-1:0]   s_value,
    input  logic [CAP_W-1:0]    capacity,
    input  bfs_cmd_t            cmd,
    output bfs_stat_t           stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [DATA_W-1:0]   m_value_res
);

    localparam int IDX_W = idx_width(QUEUE_DEPTH);
    localparam int CNT_W = cnt_width(QUEUE_DEPTH);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + 1'b1;
    endfunction

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              pending_reg, pending_next;
    logic              hit_reg, hit_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] key_reg;
    status_t           m_status_reg;
    logic [DATA_W-1:0] m_value_res_reg;
    logic [DATA_W-1:0] post_value;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              full;
    logic              out_free;

    bfs_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.enq_write),
        .wr_addr (tail_reg),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // capacity above the depth acts as the depth
    assign full = (CMP_W'(count_reg) >= CMP_W'(capacity)) || (count_reg == FULL_CNT);
    assign out_free = !m_valid_reg || m_ready;

    assign rd_en   = cmd.deq_read || (cmd.scan_step && (left_reg != '0));
    assign rd_addr = cmd.deq_read ? head_reg : ptr_reg;

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        pending_next = pending_reg;
        hit_next     = hit_reg;
        ptr_next     = ptr_reg;

        if (cmd.enq_write) begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.deq_post) begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.scan_start) begin
            hit_next     = 1'b0;
            ptr_next     = head_reg;
            left_next    = count_reg;
            pending_next = 1'b0;
        end
        if (cmd.scan_step) begin
            // compare the word read last cycle, issue the next read
            if (pending_reg && (rd_data == key_reg)) begin
                hit_next = 1'b1;
            end
            if (left_reg != '0) begin
                ptr_next     = next_slot(ptr_reg);
                left_next    = left_reg - 1'b1;
                pending_next = 1'b1;
            end else begin
                pending_next = 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.post_val)
            VAL_KEY: post_value = key_reg;
            VAL_RAM: post_value = rd_data;
            default: post_value = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.post) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            pending_reg <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            pending_reg <= pending_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load_item) begin
            func_reg <= s_func;
            key_reg  <= s_value;
        end
        if (cmd.post) begin
            m_status_reg    <= cmd.post_status;
            m_value_res_reg <= post_value;
        end
    end

    assign stat.func      = func_reg;
    assign stat.full      = full;
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_done = !pending_reg && (left_reg == '0);
    assign stat.hit       = hit_reg;
    assign stat.out_free  = out_free;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_res = m_value_res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above queue depth");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == tail_reg) |-> (count_reg == '0 || count_reg == FULL_CNT))
        else $error("head and tail agree but count is neither empty nor full");

    a_post_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> out_free)
        else $error("result posted over an untaken result");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq_write |-> !full)
        else $error("entry written while queue at capacity");

    a_deq_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq_post |-> (count_reg != '0))
        else $error("dequeue posted from an empty queue");

endmodule

// ----- design/bounded_fifo_with_search.sv -----
// ============================================================================
// bounded_fifo_with_search
// Queue of signed 32-bit words with enqueue, dequeue and key search.
// ============================================================================
// Usage:
//   Input channel s_valid/s_ready carries s_func (0 enqueue, 1 dequeue,
//   2 or 3 search) and s_value. Each transaction gives exactly one result on
//   m_valid/m_ready with m_status and m_value_res.
//   One transaction is processed at a time. A search reads the entry RAM
//   one word per cycle through its single read port, so a search lasts
//   longer the more entries the queue holds.
//   The result sits in an output register; the next transaction is taken
//   while it waits. If the receiver stalls, the following result holds in
//   the sequencer until the output register frees.
//   APB register 0 (byte address 0) is capacity_limit, reset 16; values above
//   QUEUE_DEPTH act as QUEUE_DEPTH. Write it only while the queue is idle.
//   Reset empties the queue at once; no clearing pass is needed, since only
//   written entries are ever read.
// ============================================================================
module bounded_fifo_with_search
    import bfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic signed [DATA_W-1:0] m_value_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 cfg_write;
    bfs_cmd_t             cmd;
    bfs_stat_t            stat;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_write && (reg_sel == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_CAPACITY) begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    bfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bfs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_func      (s_func),
        .s_value     (s_value),
        .capacity    (capacity_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_res (m_value_res)
    );

endmodule

// ----- verif/tb_bounded_fifo_with_search.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_bounded_fifo_with_search
// Self-checking bench for the searchable queue: a queue-fed driver sends
// enqueue, dequeue and search requests, a shadow queue predicts every reply,
// and a monitor compares each reply field by field. The capacity register is
// rewritten between phases over APB; random idling on each channel is set per phase.
// ============================================================================
module tb_bounded_fifo_with_search;
    import bfs_pkg::*;

    localparam int QUEUE_DEPTH     = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 8;

    // bit 1 selects search, so the spare code searches too
    localparam logic [FUNC_W-1:0] FUNC_SEARCH_ALT = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = APB_ADDR_W'(REG_CAPACITY) << 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(1) << 2;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] word;
    } request_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] word;
    } reply_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [FUNC_W-1:0]       s_func  = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic signed [DATA_W-1:0] m_value_res;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    bounded_fifo_with_search #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_value_res(m_value_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow of the queue state and the capacity register
    logic signed [DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    int                       shadow_head  = 0;
    int                       shadow_tail  = 0;
    int                       shadow_count = 0;
    logic [CAP_W-1:0]         shadow_cap   = CAP_RESET;

    request_t                 pending_requests[$];
    reply_t                   expected_replies[$];
    logic signed [DATA_W-1:0] enqueued_words[$];

    request_t  next_req;
    reply_t    want;
    bit        s_taken    = 1'b0;
    bit        m_taken    = 1'b0;
    bit        tx_loaded  = 1'b0;
    bit        tx_idle_on = 1'b1;
    bit        rx_idle_on = 1'b1;
    int        tx_wait    = 0;
    int        rx_wait    = 0;
    int        error_count = 0;
    int        cycle_count = 0;
    int        phase_caps[NUM_PHASES] = '{16, 31, 0, 1, 5, 17, 16, 8};

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 7)) : 0;
    endfunction

    function automatic void predict_queue_op(input logic [FUNC_W-1:0] func,
                                             input logic signed [DATA_W-1:0] word);
        reply_t reply;
        int     eff_cap;
        int     slot;
        bit     hit;
        eff_cap    = (shadow_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(shadow_cap);
        reply.word = '0;
        if (func == FUNC_SEARCH || func == FUNC_SEARCH_ALT) begin
            hit  = 1'b0;
            slot = shadow_head;
            for (int n = 0; n < shadow_count; n++) begin
                if (shadow_store[slot] == word) hit = 1'b1;
                slot = (slot + 1) % QUEUE_DEPTH;
            end
            reply.status = hit ? STATUS_FOUND : STATUS_NOT_FOUND;
            reply.word   = word;
        end else if (func == FUNC_ENQUEUE) begin
            if (shadow_count >= eff_cap) begin
                reply.status = STATUS_OVERFLOW;
            end else begin
                shadow_store[shadow_tail] = word;
                shadow_tail  = (shadow_tail + 1) % QUEUE_DEPTH;
                shadow_count++;
                reply.status = STATUS_ENQUEUED;
                reply.word   = word;
            end
        end else begin
            if (shadow_count == 0) begin
                reply.status = STATUS_UNDERFLOW;
            end else begin
                reply.word   = shadow_store[shadow_head];
                shadow_head  = (shadow_head + 1) % QUEUE_DEPTH;
                shadow_count--;
                reply.status = STATUS_DEQUEUED;
            end
        end
        expected_replies.push_back(reply);
    endfunction

    // Sample both channels and the APB access phase; check before predicting
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        m_taken <= m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected transaction: status %0d value_res %0d",
                           m_status, m_value_res);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        error_count++;
                    end
                    if (m_value_res !== want.word) begin
                        $error("value_res mismatch: expected %0d, actual %0d",
                               want.word, m_value_res);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_queue_op(s_func, s_value);
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_CAPACITY) begin
                if (pwrite) begin
                    shadow_cap = pwdata[CAP_W-1:0];
                end else if (prdata[CAP_W-1:0] !== shadow_cap) begin
                    $error("capacity_limit mismatch: expected %0d, actual %0d",
                           shadow_cap, prdata[CAP_W-1:0]);
                    error_count++;
                end
            end
        end
    end

    // Driver: load the next request once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                tx_loaded = 1'b0;
                s_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                next_req  = pending_requests.pop_front();
                tx_loaded = 1'b1;
                s_valid <= 1'b1;
                s_func  <= next_req.func;
                s_value <= next_req.word;
                tx_wait = draw_gap(tx_idle_on);
            end else begin
                tx_loaded = 1'b0;
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: when idling is on, drop m_ready for a random gap after each transaction
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_taken) begin
            rx_wait = draw_gap(rx_idle_on);
            m_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return DATA_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        if (enqueued_words.size() > 0 && $urandom_range(0, 1) == 1)
            return enqueued_words[$urandom_range(0, enqueued_words.size() - 1)];
        return pick_word();
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] func,
                                 input logic signed [DATA_W-1:0] word);
        request_t req;
        req.func = func;
        req.word = word;
        pending_requests.push_back(req);
        if (func == FUNC_ENQUEUE) begin
            enqueued_words.push_back(word);
            if (enqueued_words.size() > 32) void'(enqueued_words.pop_front());
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || tx_loaded || expected_replies.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the register with random upper bits, then read it back
    task automatic set_capacity(input int cap);
        logic [APB_DATA_W-1:0] data;
        wait_drained();
        data            = $urandom();
        data[CAP_W-1:0] = CAP_W'(cap);
        apb_access(1'b1, ADDR_CAPACITY, data);
        apb_access(1'b0, ADDR_CAPACITY, '0);
    endtask

    initial begin
        int enq_pct;
        int deq_pct;
        int r;
        logic [FUNC_W-1:0] func;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        apb_access(1'b0, ADDR_CAPACITY, '0);

        // Empty queue, extreme words, the spare search code, drain to empty
        queue_request(FUNC_DEQUEUE, 32'sh1234_5678);
        queue_request(FUNC_SEARCH, 32'sh0);
        queue_request(FUNC_ENQUEUE, 32'sh8000_0000);
        queue_request(FUNC_ENQUEUE, 32'sh7fff_ffff);
        queue_request(FUNC_ENQUEUE, 32'sh0);
        queue_request(FUNC_ENQUEUE, -32'sd1);
        queue_request(FUNC_SEARCH, -32'sd1);
        queue_request(FUNC_SEARCH_ALT, 32'sh7fff_ffff);
        queue_request(FUNC_SEARCH, 32'sh0001_2345);
        queue_request(FUNC_DEQUEUE, 32'sh0);
        queue_request(FUNC_SEARCH, 32'sh8000_0000);
        queue_request(FUNC_DEQUEUE, -32'sd1);
        queue_request(FUNC_DEQUEUE, 32'sh5555_5555);
        queue_request(FUNC_DEQUEUE, 32'shaaaa_aaaa);
        queue_request(FUNC_DEQUEUE, 32'sh0);

        // Small capacity: overflow, then lower below the count
        set_capacity(2);
        queue_request(FUNC_ENQUEUE, 32'sh0000_0011);
        queue_request(FUNC_ENQUEUE, 32'sh0000_0022);
        queue_request(FUNC_ENQUEUE, 32'sh0000_0033);
        queue_request(FUNC_DEQUEUE, 32'sh0);
        set_capacity(0);
        queue_request(FUNC_ENQUEUE, 32'sh0000_0044);
        queue_request(FUNC_SEARCH, 32'sh0000_0022);
        queue_request(FUNC_DEQUEUE, 32'sh0);
        queue_request(FUNC_ENQUEUE, 32'sh0000_0055);

        // Writes to an unmapped register must leave capacity_limit alone
        wait_drained();
        apb_access(1'b1, ADDR_UNMAPPED, $urandom());
        apb_access(1'b0, ADDR_CAPACITY, '0);

        phase_caps[NUM_PHASES-1] = $urandom_range(0, 31);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_capacity(phase_caps[ph]);
            tx_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
            rx_idle_on = (ph % 4 == 0) || (ph % 4 == 3);
            case (ph % 3)
                0: begin enq_pct = 60; deq_pct = 15; end
                1: begin enq_pct = 30; deq_pct = 45; end
                default: begin enq_pct = 40; deq_pct = 25; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < enq_pct) begin
                    queue_request(FUNC_ENQUEUE, pick_word());
                end else if (r < enq_pct + deq_pct) begin
                    queue_request(FUNC_DEQUEUE, $urandom());
                end else begin
                    func = ($urandom_range(0, 3) == 0) ? FUNC_SEARCH_ALT : FUNC_SEARCH;
                    queue_request(func, pick_key());
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
